/* sv/camera_relative_bearing_angle_core_macros.svh */
// Assertion macros for the camera relative bearing angle core.
// Expects clk and rst_n in the scope that uses them; no other dependencies.
`ifndef CAMERA_RELATIVE_BEARING_ANGLE_CORE_MACROS_SVH
`define CAMERA_RELATIVE_BEARING_ANGLE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CRBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CRBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/crba_pkg.sv */
// Package for the camera relative bearing angle core: widths, payload types
// and the CORDIC arctangent table. No dependencies.
package crba_pkg;

  // Geometry widths
  localparam int COORD_WIDTH   = 24;
  localparam int VEC_WIDTH     = 16;
  localparam int FRAC_BITS     = 14;
  localparam int DIFF_WIDTH    = COORD_WIDTH + 1;
  localparam int CROSS_WIDTH   = 2 * VEC_WIDTH;
  localparam int UPF_WIDTH     = CROSS_WIDTH - FRAC_BITS;
  localparam int XPROD_WIDTH   = VEC_WIDTH + DIFF_WIDTH;
  localparam int YPROD_WIDTH   = UPF_WIDTH + DIFF_WIDTH;
  localparam int DOT_WIDTH     = YPROD_WIDTH + 2;

  // Leading-one search, done in groups of eight bits
  localparam int GROUP_BITS    = 8;
  localparam int NUM_GROUPS    = (DOT_WIDTH + GROUP_BITS - 1) / GROUP_BITS;
  localparam int PAD_WIDTH     = NUM_GROUPS * GROUP_BITS;
  localparam int POS_WIDTH     = $clog2(PAD_WIDTH);
  localparam int LOC_WIDTH     = $clog2(GROUP_BITS);

  // Normalized vector and CORDIC datapath
  localparam int NORM_MSB      = 27;
  localparam int NORM_WIDTH    = NORM_MSB + 2;
  localparam int ROT_WIDTH     = NORM_WIDTH + 3;
  localparam int CORDIC_STAGES = 16;
  localparam int ANG_WIDTH     = 26;
  localparam int ATAN_WIDTH    = 22;
  localparam int ROUND_SHIFT   = 9;
  localparam int ROUND_BIAS    = 256;
  localparam int BEARING_WIDTH = 16;
  localparam int BEARING_MAX   = 23040;
  localparam int DEG90         = 90 * 65536;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
    logic signed [COORD_WIDTH-1:0] target_z;
    logic signed [COORD_WIDTH-1:0] camera_x;
    logic signed [COORD_WIDTH-1:0] camera_y;
    logic signed [COORD_WIDTH-1:0] camera_z;
    logic signed [VEC_WIDTH-1:0]   forward_x;
    logic signed [VEC_WIDTH-1:0]   forward_y;
    logic signed [VEC_WIDTH-1:0]   forward_z;
    logic signed [VEC_WIDTH-1:0]   up_x;
    logic signed [VEC_WIDTH-1:0]   up_y;
    logic signed [VEC_WIDTH-1:0]   up_z;
  } in_item_t;

  typedef struct packed {
    logic signed [BEARING_WIDTH-1:0] bearing;
    logic                            degenerate;
  } out_item_t;

  // atan(2^-i) in degrees, scaled by 2^16 and rounded
  function automatic logic [ATAN_WIDTH-1:0] atan_lut(input int unsigned idx);
    logic [ATAN_WIDTH-1:0] v;
    case (idx)
      0:       v = ATAN_WIDTH'(2949120);
      1:       v = ATAN_WIDTH'(1740967);
      2:       v = ATAN_WIDTH'(919879);
      3:       v = ATAN_WIDTH'(466945);
      4:       v = ATAN_WIDTH'(234379);
      5:       v = ATAN_WIDTH'(117304);
      6:       v = ATAN_WIDTH'(58666);
      7:       v = ATAN_WIDTH'(29335);
      8:       v = ATAN_WIDTH'(14668);
      9:       v = ATAN_WIDTH'(7334);
      10:      v = ATAN_WIDTH'(3667);
      11:      v = ATAN_WIDTH'(1833);
      12:      v = ATAN_WIDTH'(917);
      13:      v = ATAN_WIDTH'(458);
      14:      v = ATAN_WIDTH'(229);
      15:      v = ATAN_WIDTH'(115);
      16:      v = ATAN_WIDTH'(57);
      17:      v = ATAN_WIDTH'(29);
      18:      v = ATAN_WIDTH'(14);
      19:      v = ATAN_WIDTH'(7);
      20:      v = ATAN_WIDTH'(4);
      21:      v = ATAN_WIDTH'(2);
      22:      v = ATAN_WIDTH'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* sv/camera_relative_bearing_angle_core.sv */
// Camera relative bearing angle core: difference vector, dot products,
// normalization and a pipelined CORDIC. Uses crba_pkg and the macros header.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one item: target point,
//   camera position, unit forward and up vectors. Output channel out_valid /
//   out_stall / out_data returns one item per input: the signed bearing in
//   1/128 degree and a flag that marks target equal to camera (bearing 0).
//   An item is taken on an edge where valid is high and stall is low.
// Stages from acceptance to out_valid, in order:
//   difference, products, cross terms and forward dot, up dot products,
//   dot sum, group scan, leading-one position, normalizing shift,
//   quadrant turn, one CORDIC stage per iteration, then rounding.
// Throughput: one item per cycle when not stalled; every stage is a single register stage.
// Stall: the whole pipeline advances together; while out_valid is high and
//   out_stall is high, all stages hold and in_stall is raised, so nothing is
//   lost or repeated.
// Reset: synchronous, active low; clears all valid bits. Data registers are
//   not reset.
`include "camera_relative_bearing_angle_core_macros.svh"

module camera_relative_bearing_angle_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  crba_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output crba_pkg::out_item_t out_data
);
  import crba_pkg::*;

  localparam int NPIPE = 9 + CORDIC_STAGES;

  logic             en;
  logic [NPIPE-1:0] vld_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  // Stage 1: difference vector, vectors registered
  logic signed [DIFF_WIDTH-1:0] s1_d_r [3];
  logic signed [VEC_WIDTH-1:0]  s1_f_r [3];
  logic signed [VEC_WIDTH-1:0]  s1_u_r [3];

  // Stage 2: products
  logic signed [CROSS_WIDTH-1:0] s2_pa_r [3];
  logic signed [CROSS_WIDTH-1:0] s2_pb_r [3];
  logic signed [XPROD_WIDTH-1:0] s2_xp_r [3];
  logic signed [DIFF_WIDTH-1:0]  s2_d_r  [3];
  logic                          s2_deg_r;

  // Stage 3: up x forward and forward dot d
  logic signed [UPF_WIDTH-1:0]   s3_w_r [3];
  logic signed [DOT_WIDTH-1:0]   s3_xc_r;
  logic signed [DIFF_WIDTH-1:0]  s3_d_r [3];
  logic                          s3_deg_r;
  logic signed [CROSS_WIDTH-1:0] w_diff [3];
  logic signed [UPF_WIDTH-1:0]   w_nxt  [3];

  // Stage 4: w times d products
  logic signed [YPROD_WIDTH-1:0] s4_yp_r [3];
  logic signed [DOT_WIDTH-1:0]   s4_xc_r;
  logic                          s4_deg_r;

  // Stage 5: yc sum
  logic signed [DOT_WIDTH-1:0] s5_xc_r;
  logic signed [DOT_WIDTH-1:0] s5_yc_r;
  logic                        s5_deg_r;

  // Stage 6: group scan of max magnitude
  logic signed [DOT_WIDTH-1:0]                s6_xc_r;
  logic signed [DOT_WIDTH-1:0]                s6_yc_r;
  logic                                       s6_deg_r;
  logic [NUM_GROUPS-1:0]                      s6_nz_r;
  logic [NUM_GROUPS-1:0][LOC_WIDTH-1:0]       s6_loc_r;
  logic [DOT_WIDTH-1:0]                       mag_x;
  logic [DOT_WIDTH-1:0]                       mag_y;
  logic [PAD_WIDTH-1:0]                       m_pad;
  logic [NUM_GROUPS-1:0]                      nz_nxt;
  logic [NUM_GROUPS-1:0][LOC_WIDTH-1:0]       loc_nxt;

  // Stage 7: leading-one position
  logic signed [DOT_WIDTH-1:0] s7_xc_r;
  logic signed [DOT_WIDTH-1:0] s7_yc_r;
  logic                        s7_deg_r;
  logic                        s7_zero_r;
  logic [POS_WIDTH-1:0]        s7_pos_r;
  logic [POS_WIDTH-1:0]        pos_nxt;

  // Stage 8: normalized vector
  logic signed [NORM_WIDTH-1:0] s8_xn_r;
  logic signed [NORM_WIDTH-1:0] s8_yn_r;
  logic                         s8_deg_r;
  logic                         s8_zero_r;
  logic [POS_WIDTH-1:0]         sh_amt;
  logic signed [DOT_WIDTH-1:0]  xs_nxt;
  logic signed [DOT_WIDTH-1:0]  ys_nxt;

  // CORDIC registers: index 0 is the quadrant-turned vector
  logic signed [ROT_WIDTH-1:0] cx_r [CORDIC_STAGES+1];
  logic signed [ROT_WIDTH-1:0] cy_r [CORDIC_STAGES+1];
  logic signed [ANG_WIDTH-1:0] cz_r [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0]      cdeg_r;
  logic [CORDIC_STAGES:0]      czero_r;
  logic signed [ROT_WIDTH-1:0] cx_nxt [CORDIC_STAGES+1];
  logic signed [ROT_WIDTH-1:0] cy_nxt [CORDIC_STAGES+1];
  logic signed [ANG_WIDTH-1:0] cz_nxt [CORDIC_STAGES+1];
  logic signed [ROT_WIDTH-1:0] xe;
  logic signed [ROT_WIDTH-1:0] ye;

  // Output rounding
  logic signed [ANG_WIDTH-1:0]             z_bias;
  logic signed [ANG_WIDTH-ROUND_SHIFT-1:0] b_full;
  logic signed [BEARING_WIDTH-1:0]         b_clamp;

  // Advance all stages unless a result is held by the receiver
  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Track valid bits down the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NPIPE-2:0], in_valid};
      out_valid_r <= vld_r[NPIPE-1];
    end
  end

  // Cross terms, scaled back by FRAC_BITS
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_diff[i] = s2_pa_r[i] - s2_pb_r[i];
      w_nxt[i]  = UPF_WIDTH'(w_diff[i] >>> FRAC_BITS);
    end
  end

  // Magnitude scan: per group nonzero flag and top set bit
  always_comb begin
    mag_x = s5_xc_r[DOT_WIDTH-1] ? DOT_WIDTH'(-s5_xc_r) : DOT_WIDTH'(s5_xc_r);
    mag_y = s5_yc_r[DOT_WIDTH-1] ? DOT_WIDTH'(-s5_yc_r) : DOT_WIDTH'(s5_yc_r);
    m_pad = PAD_WIDTH'(mag_x | mag_y);
    for (int g = 0; g < NUM_GROUPS; g++) begin
      nz_nxt[g]  = |m_pad[g*GROUP_BITS +: GROUP_BITS];
      loc_nxt[g] = '0;
      for (int b = 0; b < GROUP_BITS; b++) begin
        if (m_pad[g*GROUP_BITS + b]) loc_nxt[g] = LOC_WIDTH'(b);
      end
    end
  end

  // Pick the highest nonzero group
  always_comb begin
    pos_nxt = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (s6_nz_r[g]) pos_nxt = POS_WIDTH'(g * GROUP_BITS) + POS_WIDTH'(s6_loc_r[g]);
    end
  end

  // Shift so the leading one lands on the normalized position
  always_comb begin
    if (s7_pos_r >= POS_WIDTH'(NORM_MSB)) begin
      sh_amt = s7_pos_r - POS_WIDTH'(NORM_MSB);
      xs_nxt = s7_xc_r >>> sh_amt;
      ys_nxt = s7_yc_r >>> sh_amt;
    end else begin
      sh_amt = POS_WIDTH'(NORM_MSB) - s7_pos_r;
      xs_nxt = s7_xc_r <<< sh_amt;
      ys_nxt = s7_yc_r <<< sh_amt;
    end
  end

  // Quadrant turn and CORDIC micro-rotations
  always_comb begin
    xe = ROT_WIDTH'(s8_xn_r);
    ye = ROT_WIDTH'(s8_yn_r);
    if (xe < 0) begin
      if (ye >= 0) begin
        cx_nxt[0] = ye;
        cy_nxt[0] = -xe;
        cz_nxt[0] = ANG_WIDTH'(DEG90);
      end else begin
        cx_nxt[0] = -ye;
        cy_nxt[0] = xe;
        cz_nxt[0] = -ANG_WIDTH'(DEG90);
      end
    end else begin
      cx_nxt[0] = xe;
      cy_nxt[0] = ye;
      cz_nxt[0] = '0;
    end
    for (int k = 0; k < CORDIC_STAGES; k++) begin
      if (cy_r[k] > 0) begin
        cx_nxt[k+1] = cx_r[k] + (cy_r[k] >>> k);
        cy_nxt[k+1] = cy_r[k] - (cx_r[k] >>> k);
        cz_nxt[k+1] = cz_r[k] + ANG_WIDTH'(atan_lut(k));
      end else begin
        cx_nxt[k+1] = cx_r[k] - (cy_r[k] >>> k);
        cy_nxt[k+1] = cy_r[k] + (cx_r[k] >>> k);
        cz_nxt[k+1] = cz_r[k] - ANG_WIDTH'(atan_lut(k));
      end
    end
  end

  // Round to 1/128 degree and clamp
  always_comb begin
    z_bias = cz_r[CORDIC_STAGES] + ANG_WIDTH'(ROUND_BIAS);
    b_full = (ANG_WIDTH-ROUND_SHIFT)'(z_bias >>> ROUND_SHIFT);
    if (b_full > (ANG_WIDTH-ROUND_SHIFT)'(BEARING_MAX)) begin
      b_clamp = BEARING_WIDTH'(BEARING_MAX);
    end else if (b_full < -(ANG_WIDTH-ROUND_SHIFT)'(BEARING_MAX)) begin
      b_clamp = -BEARING_WIDTH'(BEARING_MAX);
    end else begin
      b_clamp = BEARING_WIDTH'(b_full);
    end
  end

  // Datapath registers; advance with the pipeline enable
  always_ff @(posedge clk) begin
    if (en) begin
      // difference vector
      s1_d_r[0] <= DIFF_WIDTH'(in_data.target_x) - DIFF_WIDTH'(in_data.camera_x);
      s1_d_r[1] <= DIFF_WIDTH'(in_data.target_y) - DIFF_WIDTH'(in_data.camera_y);
      s1_d_r[2] <= DIFF_WIDTH'(in_data.target_z) - DIFF_WIDTH'(in_data.camera_z);
      s1_f_r[0] <= in_data.forward_x;
      s1_f_r[1] <= in_data.forward_y;
      s1_f_r[2] <= in_data.forward_z;
      s1_u_r[0] <= in_data.up_x;
      s1_u_r[1] <= in_data.up_y;
      s1_u_r[2] <= in_data.up_z;

      // products
      for (int i = 0; i < 3; i++) begin
        s2_pa_r[i] <= CROSS_WIDTH'(s1_u_r[(i+1)%3]) * CROSS_WIDTH'(s1_f_r[(i+2)%3]);
        s2_pb_r[i] <= CROSS_WIDTH'(s1_u_r[(i+2)%3]) * CROSS_WIDTH'(s1_f_r[(i+1)%3]);
        s2_xp_r[i] <= XPROD_WIDTH'(s1_f_r[i]) * XPROD_WIDTH'(s1_d_r[i]);
        s2_d_r[i]  <= s1_d_r[i];
      end
      s2_deg_r <= (s1_d_r[0] == '0) && (s1_d_r[1] == '0) && (s1_d_r[2] == '0);

      // cross vector and forward dot
      for (int i = 0; i < 3; i++) begin
        s3_w_r[i] <= w_nxt[i];
        s3_d_r[i] <= s2_d_r[i];
      end
      s3_xc_r  <= DOT_WIDTH'(s2_xp_r[0]) + DOT_WIDTH'(s2_xp_r[1]) + DOT_WIDTH'(s2_xp_r[2]);
      s3_deg_r <= s2_deg_r;

      // up-side products
      for (int i = 0; i < 3; i++) begin
        s4_yp_r[i] <= YPROD_WIDTH'(s3_w_r[i]) * YPROD_WIDTH'(s3_d_r[i]);
      end
      s4_xc_r  <= s3_xc_r;
      s4_deg_r <= s3_deg_r;

      // up-side dot
      s5_yc_r  <= DOT_WIDTH'(s4_yp_r[0]) + DOT_WIDTH'(s4_yp_r[1]) + DOT_WIDTH'(s4_yp_r[2]);
      s5_xc_r  <= s4_xc_r;
      s5_deg_r <= s4_deg_r;

      // group scan
      s6_xc_r  <= s5_xc_r;
      s6_yc_r  <= s5_yc_r;
      s6_deg_r <= s5_deg_r;
      s6_nz_r  <= nz_nxt;
      s6_loc_r <= loc_nxt;

      // leading-one position
      s7_xc_r   <= s6_xc_r;
      s7_yc_r   <= s6_yc_r;
      s7_deg_r  <= s6_deg_r;
      s7_zero_r <= ~|s6_nz_r;
      s7_pos_r  <= pos_nxt;

      // normalized vector
      s8_xn_r   <= NORM_WIDTH'(xs_nxt);
      s8_yn_r   <= NORM_WIDTH'(ys_nxt);
      s8_deg_r  <= s7_deg_r;
      s8_zero_r <= s7_zero_r;

      // CORDIC chain
      for (int k = 0; k <= CORDIC_STAGES; k++) begin
        cx_r[k] <= cx_nxt[k];
        cy_r[k] <= cy_nxt[k];
        cz_r[k] <= cz_nxt[k];
      end
      cdeg_r  <= {cdeg_r[CORDIC_STAGES-1:0], s8_deg_r};
      czero_r <= {czero_r[CORDIC_STAGES-1:0], s8_zero_r};

      // result
      out_data_r.degenerate <= cdeg_r[CORDIC_STAGES];
      out_data_r.bearing    <= (cdeg_r[CORDIC_STAGES] || czero_r[CORDIC_STAGES]) ?
                               '0 : b_clamp;
    end
  end

  // Checks
  `CRBA_ASSERT_NOW(a_degen_bearing_zero, out_valid_r && out_data_r.degenerate, out_data_r.bearing == '0, "degenerate item with nonzero bearing")
  `CRBA_ASSERT_NOW(a_bearing_range, out_valid_r, ($signed(out_data_r.bearing) <= 16'sd23040) && ($signed(out_data_r.bearing) >= -16'sd23040), "bearing out of range")
  `CRBA_ASSERT_NEXT(a_hold_on_stall, !en, $stable(vld_r) && $stable(out_valid_r), "pipeline moved while held")
  `CRBA_ASSERT_NOW(a_degen_dots_zero, vld_r[6] && s7_deg_r, s7_zero_r, "zero difference with nonzero dot terms")

endmodule

/* sim/camera_relative_bearing_angle_core_checker.sv */
// Checker for the camera relative bearing angle core: watches both channels,
// predicts each bearing from the accepted item and compares. Uses crba_pkg.
module camera_relative_bearing_angle_core_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  crba_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  crba_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  outstanding,
  output int                  results_checked,
  output int                  degenerate_seen
);
  import crba_pkg::*;

  localparam int     MAX_REPORTS = 100;
  localparam int     ARCTAN_ENTRIES = 24;
  localparam longint NORM_LO = longint'(1) << NORM_MSB;
  localparam longint NORM_HI = longint'(1) << (NORM_MSB + 1);

  out_item_t bearing_expected_q[$];
  out_item_t expected_item;

  // atan(2^-i) in degrees, 16 fractional bits
  function automatic longint arctan_step(input int i);
    case (i)
      0:       return 2949120;
      1:       return 1740967;
      2:       return 919879;
      3:       return 466945;
      4:       return 234379;
      5:       return 117304;
      6:       return 58666;
      7:       return 29335;
      8:       return 14668;
      9:       return 7334;
      10:      return 3667;
      11:      return 1833;
      12:      return 917;
      13:      return 458;
      14:      return 229;
      15:      return 115;
      16:      return 57;
      17:      return 29;
      18:      return 14;
      19:      return 7;
      20:      return 4;
      21:      return 2;
      22:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Bearing of the difference vector in the camera frame, 1/128 degree
  function automatic out_item_t predict_bearing(input in_item_t it);
    longint    dx, dy, dz, fx, fy, fz, ux, uy, uz, wx, wy, wz;
    longint    xc, yc, x, y, z, m, t, xs, ys, b;
    int        i;
    out_item_t r;
    r.bearing    = '0;
    r.degenerate = 1'b0;
    dx = longint'($signed(it.target_x)) - longint'($signed(it.camera_x));
    dy = longint'($signed(it.target_y)) - longint'($signed(it.camera_y));
    dz = longint'($signed(it.target_z)) - longint'($signed(it.camera_z));
    fx = longint'($signed(it.forward_x));
    fy = longint'($signed(it.forward_y));
    fz = longint'($signed(it.forward_z));
    ux = longint'($signed(it.up_x));
    uy = longint'($signed(it.up_y));
    uz = longint'($signed(it.up_z));
    // target on the camera: flag it, bearing zero
    if (dx == 0 && dy == 0 && dz == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    // up cross forward, back to 14 fractional bits with floor
    wx = (uy * fz - uz * fy) >>> FRAC_BITS;
    wy = (uz * fx - ux * fz) >>> FRAC_BITS;
    wz = (ux * fy - uy * fx) >>> FRAC_BITS;
    xc = fx * dx + fy * dy + fz * dz;
    yc = wx * dx + wy * dy + wz * dz;
    if (xc == 0 && yc == 0) begin
      return r;
    end
    // scale so the larger magnitude sits just under the top bit
    m = (magnitude(xc) > magnitude(yc)) ? magnitude(xc) : magnitude(yc);
    while (m >= NORM_HI) begin
      xc = xc >>> 1;
      yc = yc >>> 1;
      m  = m >>> 1;
    end
    while (m < NORM_LO) begin
      xc = xc * 2;
      yc = yc * 2;
      m  = m * 2;
    end
    // turn the left half plane into the right one
    z = 0;
    if (xc < 0) begin
      if (yc >= 0) begin
        x = yc;
        y = -xc;
        z = longint'(DEG90);
      end else begin
        x = -yc;
        y = xc;
        z = -longint'(DEG90);
      end
    end else begin
      x = xc;
      y = yc;
    end
    // vectoring iterations drive y toward zero
    for (i = 0; i < CORDIC_STAGES && i < ARCTAN_ENTRIES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        t = x + ys;
        y = y - xs;
        z = z + arctan_step(i);
      end else begin
        t = x - ys;
        y = y + xs;
        z = z - arctan_step(i);
      end
      x = t;
    end
    b = (z + ROUND_BIAS) >>> ROUND_SHIFT;
    if (b > BEARING_MAX) b = BEARING_MAX;
    if (b < -BEARING_MAX) b = -BEARING_MAX;
    r.bearing = BEARING_WIDTH'(b);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
  endtask

  // Queue a prediction per accepted item, compare per accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        bearing_expected_q.push_back(predict_bearing(in_data));
      end
      if (out_valid && !out_stall) begin
        if (bearing_expected_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: bearing %0d degenerate %0b",
                                    out_data.bearing, out_data.degenerate));
        end else begin
          expected_item = bearing_expected_q.pop_front();
          results_checked++;
          if (expected_item.degenerate) degenerate_seen++;
          if (out_data.bearing !== expected_item.bearing) begin
            report_mismatch($sformatf("result %0d: bearing %0d, expected %0d",
                                      results_checked, out_data.bearing,
                                      expected_item.bearing));
          end
          if (out_data.degenerate !== expected_item.degenerate) begin
            report_mismatch($sformatf("result %0d: degenerate %0b, expected %0b",
                                      results_checked, out_data.degenerate,
                                      expected_item.degenerate));
          end
        end
      end
    end
    outstanding <= bearing_expected_q.size();
  end

endmodule

/* sim/camera_relative_bearing_angle_core_tb.sv */
// Testbench top for the camera relative bearing angle core: clock, reset,
// directed and random items, output stalls and the verdict. Uses crba_pkg.
module camera_relative_bearing_angle_core_tb;
  import crba_pkg::*;

  localparam int RANDOM_ITEMS     = 1200;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 40;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int QUIET_FIRST      = 400;
  localparam int QUIET_LAST       = 600;
  localparam int HOLD_AT_ITEM     = 800;
  localparam int VEC_ONE          = 1 << FRAC_BITS;
  localparam int COORD_MAX        = (1 << (COORD_WIDTH - 1)) - 1;
  localparam int COORD_MIN        = -(1 << (COORD_WIDTH - 1));

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int outstanding;
  int results_checked;
  int degenerate_seen;
  int cycle_count   = 0;
  int items_sent    = 0;
  int hold_requests = 0;
  bit quiet         = 1'b0;

  always #4 clk = ~clk;

  camera_relative_bearing_angle_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  camera_relative_bearing_angle_core_checker bearing_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .degenerate_seen(degenerate_seen)
  );

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("camera_relative_bearing_angle_core test failed");
      $finish;
    end
  end

  // Output side: random stalls, none in the quiet stretch, one long hold-off
  initial begin
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_requests > holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 30);
      end
    end
  end

  function automatic in_item_t make_item(input int tx, input int ty, input int tz,
                                         input int cx, input int cy, input int cz,
                                         input int fx, input int fy, input int fz,
                                         input int ux, input int uy, input int uz);
    in_item_t it;
    it.target_x  = COORD_WIDTH'(tx);
    it.target_y  = COORD_WIDTH'(ty);
    it.target_z  = COORD_WIDTH'(tz);
    it.camera_x  = COORD_WIDTH'(cx);
    it.camera_y  = COORD_WIDTH'(cy);
    it.camera_z  = COORD_WIDTH'(cz);
    it.forward_x = VEC_WIDTH'(fx);
    it.forward_y = VEC_WIDTH'(fy);
    it.forward_z = VEC_WIDTH'(fz);
    it.up_x      = VEC_WIDTH'(ux);
    it.up_y      = VEC_WIDTH'(uy);
    it.up_z      = VEC_WIDTH'(uz);
    return it;
  endfunction

  function automatic int unit_range();
    return int'($urandom_range(2 * VEC_ONE)) - VEC_ONE;
  endfunction

  function automatic int axis_sign();
    return $urandom_range(1) ? VEC_ONE : -VEC_ONE;
  endfunction

  // Mix of generic, near-camera, degenerate, raw-pattern and axis frames
  function automatic in_item_t random_item();
    int kind, fa, ua, k;
    int t[3], c[3], f[3], u[3];
    kind = $urandom_range(99);
    for (k = 0; k < 3; k++) begin
      c[k] = int'($urandom);
      t[k] = int'($urandom);
      f[k] = unit_range();
      u[k] = unit_range();
    end
    if (kind < 15) begin
      // target a few steps from the camera
      for (k = 0; k < 3; k++) t[k] = c[k] + int'($urandom_range(16)) - 8;
    end else if (kind < 22) begin
      // target on the camera
      for (k = 0; k < 3; k++) t[k] = c[k];
    end else if (kind < 35) begin
      // any bit pattern on the vectors
      for (k = 0; k < 3; k++) begin
        f[k] = int'($urandom);
        u[k] = int'($urandom);
      end
    end else if (kind < 65) begin
      // axis-aligned frame, offsets on the axes
      fa = $urandom_range(2);
      ua = (fa + 1 + $urandom_range(1)) % 3;
      for (k = 0; k < 3; k++) begin
        f[k] = 0;
        u[k] = 0;
      end
      f[fa] = axis_sign();
      u[ua] = axis_sign();
      if (kind < 55) begin
        for (k = 0; k < 3; k++) begin
          t[k] = c[k] + (int'($urandom_range(2)) - 1) * int'($urandom_range(1, 4096));
        end
      end else begin
        // nearly behind the camera
        for (k = 0; k < 3; k++) t[k] = c[k] + int'($urandom_range(4)) - 2;
        t[fa] = c[fa] - (f[fa] / VEC_ONE) * int'($urandom_range(1, 1000000));
      end
    end
    return make_item(t[0], t[1], t[2], c[0], c[1], c[2],
                     f[0], f[1], f[2], u[0], u[1], u[2]);
  endfunction

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_item(input in_item_t it);
    while (!quiet && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  initial begin
    int n;
    int directed_count;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // target on the camera, including the extremes and all ones
    send_item(make_item(100, 200, 300, 100, 200, 300, VEC_ONE, 0, 0, 0, 0, VEC_ONE));
    send_item(make_item(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                        -32768, 32767, -32768, 32767, -32768, 32767));
    send_item(make_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        VEC_ONE, 0, 0, 0, 0, VEC_ONE));
    send_item(make_item(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    // both dot terms zero: offset along up, then no forward vector
    send_item(make_item(0, 0, 100, 0, 0, 0, VEC_ONE, 0, 0, 0, 0, VEC_ONE));
    send_item(make_item(5, 6, 7, 0, 0, 0, 0, 0, 0, 0, 0, VEC_ONE));
    // ahead, behind, left, right and just off behind
    send_item(make_item(100, 0, 0, 0, 0, 0, VEC_ONE, 0, 0, 0, 0, VEC_ONE));
    send_item(make_item(-100, 0, 0, 0, 0, 0, VEC_ONE, 0, 0, 0, 0, VEC_ONE));
    send_item(make_item(0, 100, 0, 0, 0, 0, VEC_ONE, 0, 0, 0, 0, VEC_ONE));
    send_item(make_item(0, -100, 0, 0, 0, 0, VEC_ONE, 0, 0, 0, 0, VEC_ONE));
    send_item(make_item(-100, 1, 0, 0, 0, 0, VEC_ONE, 0, 0, 0, 0, VEC_ONE));
    send_item(make_item(-100, -1, 0, 0, 0, 0, VEC_ONE, 0, 0, 0, 0, VEC_ONE));
    // widest differences both ways
    send_item(make_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                        VEC_ONE, 0, 0, 0, 0, VEC_ONE));
    send_item(make_item(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                        VEC_ONE, 0, 0, 0, 0, VEC_ONE));
    send_item(make_item(COORD_MAX, 0, 0, COORD_MIN, 0, 0, 0, VEC_ONE, 0, VEC_ONE, 0, 0));
    // vector components outside the unit range
    send_item(make_item(1000, -2000, 3000, -5, 7, 9,
                        -32768, -32768, -32768, 32767, 32767, 32767));
    send_item(make_item(-4000, 2500, 123, 11, -13, 17,
                        32767, -32768, 32767, -32768, 32767, -32768));
    send_item(make_item(1, 1, 1, 0, 0, 0, -VEC_ONE, 0, 0, 0, -VEC_ONE, 0));
    // forward parallel to up leaves no side component
    send_item(make_item(1, 2, 3, 0, 0, 0, VEC_ONE, VEC_ONE, VEC_ONE,
                        -VEC_ONE, -VEC_ONE, -VEC_ONE));
    // tiny products that need a large left shift
    send_item(make_item(1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1));
    send_item(make_item(1, 0, 0, 0, 0, 0, -1, 0, 0, 0, 0, 1));
    send_item(make_item(3, -4, 5, 0, 0, 0, 0, VEC_ONE, 0, VEC_ONE, 0, 0));
    directed_count = items_sent;

    // random items with a quiet stretch and one long output hold-off
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
      if (n == HOLD_AT_ITEM) hold_requests++;
      send_item(random_item());
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // drain the pipeline
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d directed, %0d random), checked %0d results, %0d degenerate.",
             items_sent, directed_count, items_sent - directed_count, results_checked,
             degenerate_seen);
    $display("Random input and output stalls, a stall-free stretch and a %0d-cycle hold-off.",
             LONG_HOLD_CYCLES);
    if (fail_count == 0 && outstanding == 0) begin
      $display("camera_relative_bearing_angle_core test passed");
    end else begin
      $display("camera_relative_bearing_angle_core test failed");
    end
    $finish;
  end

endmodule
